// File: rtl/core/stable_min_priority_queue_defines.svh
// Assertion macros used by the checker file of the priority queue.
// No dependencies; expects clk_i and rst_ni in the scope of each use.
`ifndef STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/smpq_pkg.sv
// Package of the sorted priority queue: command and status codes, cell control.
// No dependencies.
package smpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned OCC_BITS = 5;
  localparam int unsigned CMD_BITS = 2;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     occ;
  } cell_ctl_t;

endpackage

// File: rtl/core/smpq_if.sv
// Handshake interfaces of the priority queue: command channel and result channel.
// Depends on smpq_pkg.
interface smpq_cmd_if #(
  parameter int unsigned KEY_BITS = smpq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = smpq_pkg::TAG_BITS
);
  logic                              valid;
  logic                              ready;
  logic [smpq_pkg::CMD_BITS-1:0]     command;
  logic [KEY_BITS-1:0]               key;
  logic [TAG_BITS-1:0]               payload_tag;

  modport source (output valid, command, key, payload_tag, input ready);
  modport sink   (input valid, command, key, payload_tag, output ready);
endinterface

interface smpq_res_if #(
  parameter int unsigned KEY_BITS = smpq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = smpq_pkg::TAG_BITS
);
  logic                              valid;
  logic                              ready;
  logic [smpq_pkg::STATUS_BITS-1:0]  status;
  logic                              popped_valid;
  logic [KEY_BITS-1:0]               popped_key;
  logic [TAG_BITS-1:0]               popped_tag;
  logic [smpq_pkg::OCC_BITS-1:0]     occupancy;

  modport source (output valid, status, popped_valid, popped_key, popped_tag, occupancy,
                  input ready);
  modport sink   (input valid, status, popped_valid, popped_key, popped_tag, occupancy,
                  output ready);
endinterface

// File: rtl/core/smpq_cell.sv
// One slot of the sorted shift array: holds a key and tag, moves left, right or holds.
// Depends on smpq_pkg.
module smpq_cell #(
  parameter int unsigned KEY_BITS = smpq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = smpq_pkg::TAG_BITS
) (
  input  logic                  clk_i,
  input  smpq_pkg::cell_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]   new_key_i,
  input  logic [TAG_BITS-1:0]   new_tag_i,
  input  logic                  left_le_i,
  input  logic [KEY_BITS-1:0]   left_key_i,
  input  logic [TAG_BITS-1:0]   left_tag_i,
  input  logic [KEY_BITS-1:0]   right_key_i,
  input  logic [TAG_BITS-1:0]   right_tag_i,
  output logic                  le_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [TAG_BITS-1:0]   tag_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // equal keys stay ahead of the new entry
  assign le_o = ctl_i.occ && (key_q <= new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    unique case (ctl_i.op)
      smpq_pkg::OP_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            key_d = new_key_i;
            tag_d = new_tag_i;
          end else begin
            key_d = left_key_i;
            tag_d = left_tag_i;
          end
        end
      end
      smpq_pkg::OP_POP: begin
        key_d = right_key_i;
        tag_d = right_tag_i;
      end
      default: begin
        key_d = key_q;
        tag_d = tag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

// File: rtl/core/stable_min_priority_queue.sv
// Sorted priority queue built as a row of shift cells, smallest key at the front.
// A command's result appears in the output register in the cycle after acceptance.
// Throughput: one command per cycle while the result channel is not stalled; every cell updates in parallel.
// Reset clears the entry count and the result valid flag; cells and result fields stay unset.
// Depends on smpq_pkg, smpq_if and smpq_cell.
module stable_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::CAPACITY,
  parameter int unsigned KEY_BITS = smpq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = smpq_pkg::TAG_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  smpq_cmd_if.sink   cmd_i,
  smpq_res_if.source res_o
);

  localparam int unsigned CntBits = $clog2(CAPACITY + 1);
  localparam int unsigned OccBits = smpq_pkg::OCC_BITS;
  localparam logic [CntBits-1:0] CntFull = CntBits'(CAPACITY);

  logic [CntBits-1:0] count_q, count_d;
  logic               fire;
  smpq_pkg::cell_op_e op;

  logic                            res_valid_q, res_valid_d;
  logic [smpq_pkg::STATUS_BITS-1:0] status_q, status_d;
  logic                            pvalid_q, pvalid_d;
  logic [KEY_BITS-1:0]             pkey_q, pkey_d;
  logic [TAG_BITS-1:0]             ptag_q, ptag_d;
  logic [OccBits-1:0]              occ_q, occ_d;
  logic [CntBits+OccBits-1:0]      count_wide;

  logic                cell_le  [CAPACITY];
  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [TAG_BITS-1:0] cell_tag [CAPACITY];

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign fire        = cmd_i.valid && cmd_i.ready;

  // command decode
  always_comb begin
    op       = smpq_pkg::OP_HOLD;
    count_d  = count_q;
    status_d = smpq_pkg::ST_OK;
    pvalid_d = 1'b0;
    pkey_d   = '0;
    ptag_d   = '0;
    if (fire) begin
      unique case (cmd_i.command)
        smpq_pkg::CMD_INSERT: begin
          if (count_q == CntFull) begin
            status_d = smpq_pkg::ST_FULL;
          end else begin
            op      = smpq_pkg::OP_INSERT;
            count_d = count_q + 1'b1;
          end
        end
        smpq_pkg::CMD_POP: begin
          if (count_q == '0) begin
            status_d = smpq_pkg::ST_EMPTY;
          end else begin
            op       = smpq_pkg::OP_POP;
            count_d  = count_q - 1'b1;
            pvalid_d = 1'b1;
            pkey_d   = cell_key[0];
            ptag_d   = cell_tag[0];
          end
        end
        smpq_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  assign count_wide  = {{OccBits{1'b0}}, count_d};
  assign occ_d       = count_wide[OccBits-1:0];
  assign res_valid_d = fire ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smpq_pkg::cell_ctl_t ctl;
    logic                left_le;
    logic [KEY_BITS-1:0] left_key, right_key;
    logic [TAG_BITS-1:0] left_tag, right_tag;

    assign ctl.op  = op;
    assign ctl.occ = (count_q > CntBits'(i));

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_key = cmd_i.key;
      assign left_tag = cmd_i.payload_tag;
    end else begin : g_mid
      assign left_le  = cell_le[i-1];
      assign left_key = cell_key[i-1];
      assign left_tag = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
      assign right_tag = cell_tag[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_tag = cell_tag[i+1];
    end

    smpq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_key_i   (cmd_i.key),
      .new_tag_i   (cmd_i.payload_tag),
      .left_le_i   (left_le),
      .left_key_i  (left_key),
      .left_tag_i  (left_tag),
      .right_key_i (right_key),
      .right_tag_i (right_tag),
      .le_o        (cell_le[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      pvalid_q <= pvalid_d;
      pkey_q   <= pkey_d;
      ptag_q   <= ptag_d;
      occ_q    <= occ_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = status_q;
  assign res_o.popped_valid = pvalid_q;
  assign res_o.popped_key   = pkey_q;
  assign res_o.popped_tag   = ptag_q;
  assign res_o.occupancy    = occ_q;

endmodule

// File: rtl/core/smpq_checker.sv
// Port-level checks of the priority queue result channel, bound to the top level.
// Depends on smpq_pkg and stable_min_priority_queue_defines.svh.
`include "stable_min_priority_queue_defines.svh"

module smpq_checker #(
  parameter int unsigned CAPACITY = smpq_pkg::CAPACITY,
  parameter int unsigned KEY_BITS = smpq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = smpq_pkg::TAG_BITS
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic [smpq_pkg::STATUS_BITS-1:0] status_i,
  input logic                             popped_valid_i,
  input logic [KEY_BITS-1:0]              popped_key_i,
  input logic [TAG_BITS-1:0]              popped_tag_i,
  input logic [smpq_pkg::OCC_BITS-1:0]    occupancy_i
);

  localparam int unsigned OccBits = smpq_pkg::OCC_BITS;
  localparam int unsigned FieldBits = smpq_pkg::STATUS_BITS + 1 + KEY_BITS + TAG_BITS + OccBits;
  localparam logic [OccBits-1:0] FullOcc = OccBits'(CAPACITY);

  logic                 stalled;
  logic                 is_empty;
  logic                 empty_ok;
  logic                 is_full;
  logic                 full_ok;
  logic                 no_entry;
  logic                 zero_fields;
  logic [FieldBits-1:0] res_fields;

  assign stalled     = res_valid_i && !res_ready_i;
  assign res_fields  = {status_i, popped_valid_i, popped_key_i, popped_tag_i, occupancy_i};
  assign is_empty    = res_valid_i && status_i == smpq_pkg::ST_EMPTY;
  assign empty_ok    = !popped_valid_i && occupancy_i == '0;
  assign is_full     = res_valid_i && status_i == smpq_pkg::ST_FULL;
  assign full_ok     = occupancy_i == FullOcc && !popped_valid_i;
  assign no_entry    = res_valid_i && !popped_valid_i;
  assign zero_fields = popped_key_i == '0 && popped_tag_i == '0;

  // a stalled transaction keeps its contents
  `SMPQ_ASSERT_NEXT(a_hold, stalled, res_valid_i && $stable(res_fields), "stalled result changed")

  `SMPQ_ASSERT_NOW(a_empty_pop, is_empty, empty_ok, "empty pop reports entry or occupancy")

  `SMPQ_ASSERT_NOW(a_full_occ, is_full, full_ok, "full insert with wrong occupancy")

  `SMPQ_ASSERT_NOW(a_no_entry_zero, no_entry, zero_fields, "popped fields not zero")

endmodule

bind stable_min_priority_queue smpq_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS)
) u_smpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .status_i       (res_o.status),
  .popped_valid_i (res_o.popped_valid),
  .popped_key_i   (res_o.popped_key),
  .popped_tag_i   (res_o.popped_tag),
  .occupancy_i    (res_o.occupancy)
);
